[rtl/grid_cell_bayes_update_defines.svh]
// Assertion macros shared by the grid cell update RTL.
`ifndef GRID_CELL_BAYES_UPDATE_DEFINES_SVH
`define GRID_CELL_BAYES_UPDATE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted
`define GCBU_ASSERT_IMPLIES(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("gcbu assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define GCBU_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("gcbu assertion failed");

`else

`define GCBU_ASSERT_IMPLIES(label, clk, rst_n, cond, prop)
`define GCBU_ASSERT_NEXT(label, clk, rst_n, cond, prop)

`endif

`endif

[rtl/gcbu_pkg.sv]
// Shared constants, types and helper functions of the grid cell update block.
package gcbu_pkg;

    // Map and number format
    localparam int NUM_CELLS      = 65536;
    localparam int PROB_FRAC_BITS = 16;
    localparam int CELL_AW        = $clog2(NUM_CELLS);
    localparam int PROB_W         = PROB_FRAC_BITS + 1;
    localparam int PROD_W         = 2 * PROB_W;
    localparam int DEN_W          = 2 * PROB_FRAC_BITS + 1;
    localparam int DIV_CNT_W      = $clog2(PROB_FRAC_BITS);
    localparam int ONE_Q          = 1 << PROB_FRAC_BITS;

    // Port field widths
    localparam int IDX_W      = 16;
    localparam int LIK_W      = 17;
    localparam int OUT_PROB_W = 17;
    localparam int ACT_W      = 2;
    localparam int REG_W      = 16;

    // Configuration port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_PRIOR = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_UPPER = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_LOWER = 2'd2;

    localparam logic [REG_W-1:0] PRIOR_RESET = 16'd52429;
    localparam logic [REG_W-1:0] UPPER_RESET = 16'd52429;
    localparam logic [REG_W-1:0] LOWER_RESET = 16'd13107;

    // Result action codes
    localparam logic [ACT_W-1:0] ACT_FUSE  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_PRIOR = 2'd1;
    localparam logic [ACT_W-1:0] ACT_SKIP  = 2'd2;

    typedef struct packed {
        logic [IDX_W-1:0] cell_index;
        logic [LIK_W-1:0] likelihood;
        logic             likelihood_valid;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0]      cell_index_out;
        logic [OUT_PROB_W-1:0] probability;
        logic [ACT_W-1:0]      action;
    } out_item_t;

    typedef struct packed {
        logic [REG_W-1:0] prior_prob;
        logic [REG_W-1:0] upper_prob;
        logic [REG_W-1:0] lower_prob;
    } cfg_t;

    // Controller to datapath commands
    typedef struct packed {
        logic in_load;
        logic clear_step;
        logic mem_rd;
        logic mul_num;
        logic mul_odd;
        logic den_load;
        logic div_init;
        logic div_step;
        logic commit;
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic clear_last;
        logic fuse_path;
        logic out_free;
    } dp_status_t;

    // Limit an unsigned Q16.16 value to one, giving Q1.16
    function automatic logic [PROB_W-1:0] sat_one(input logic [31:0] v);
        logic [PROB_W-1:0] r;
        if (v > 32'(ONE_Q))
        begin
            r = PROB_W'(ONE_Q);
        end
        else
        begin
            r = PROB_W'(v);
        end
        return r;
    endfunction

endpackage

[rtl/gcbu_regs.sv]
// APB-style configuration registers: prior, upper and lower probability.
module gcbu_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [gcbu_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [gcbu_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [gcbu_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    output gcbu_pkg::cfg_t                    cfg
);

    logic [gcbu_pkg::REG_W-1:0]     prior_reg;
    logic [gcbu_pkg::REG_W-1:0]     upper_reg;
    logic [gcbu_pkg::REG_W-1:0]     lower_reg;
    logic [gcbu_pkg::REG_IDX_W-1:0] reg_idx;
    logic                           wr_en;

    assign reg_idx = paddr[gcbu_pkg::APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // Write a register on the access phase of a transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prior_reg <= gcbu_pkg::PRIOR_RESET;
            upper_reg <= gcbu_pkg::UPPER_RESET;
            lower_reg <= gcbu_pkg::LOWER_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                gcbu_pkg::REG_PRIOR: prior_reg <= pwdata[gcbu_pkg::REG_W-1:0];
                gcbu_pkg::REG_UPPER: upper_reg <= pwdata[gcbu_pkg::REG_W-1:0];
                gcbu_pkg::REG_LOWER: lower_reg <= pwdata[gcbu_pkg::REG_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        case (reg_idx)
            gcbu_pkg::REG_PRIOR: prdata = gcbu_pkg::APB_DATA_W'(prior_reg);
            gcbu_pkg::REG_UPPER: prdata = gcbu_pkg::APB_DATA_W'(upper_reg);
            gcbu_pkg::REG_LOWER: prdata = gcbu_pkg::APB_DATA_W'(lower_reg);
            default:             prdata = '0;
        endcase
    end

    assign cfg.prior_prob = prior_reg;
    assign cfg.upper_prob = upper_reg;
    assign cfg.lower_prob = lower_reg;

endmodule

[rtl/gcbu_ctrl.sv]
// Sequencer: known-bit clearing sweep, cell read, multiply, divide and commit steps.
module gcbu_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    item_valid,
    output logic                    item_ready,
    input  gcbu_pkg::dp_status_t    status,
    output gcbu_pkg::ctrl_cmd_t     cmd
);

    typedef enum logic [9:0] {
        ST_CLEAR    = 10'b0000000001,
        ST_IDLE     = 10'b0000000010,
        ST_READ     = 10'b0000000100,
        ST_DECIDE   = 10'b0000001000,
        ST_MUL_NUM  = 10'b0000010000,
        ST_MUL_ODD  = 10'b0000100000,
        ST_DEN      = 10'b0001000000,
        ST_DIV_INIT = 10'b0010000000,
        ST_DIV      = 10'b0100000000,
        ST_WRITE    = 10'b1000000000
    } state_t;

    state_t                         state_reg;
    state_t                         state_next;
    logic [gcbu_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [gcbu_pkg::DIV_CNT_W-1:0] cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign item_ready = (state_reg == ST_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.in_load = item_valid && (state_reg == ST_IDLE);
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.mem_rd = 1'b1;
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                state_next = status.fuse_path ? ST_MUL_NUM : ST_WRITE;
            end
            ST_MUL_NUM:
            begin
                cmd.mul_num = 1'b1;
                state_next  = ST_MUL_ODD;
            end
            ST_MUL_ODD:
            begin
                cmd.mul_odd = 1'b1;
                state_next  = ST_DEN;
            end
            ST_DEN:
            begin
                cmd.den_load = 1'b1;
                state_next   = ST_DIV_INIT;
            end
            ST_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == gcbu_pkg::DIV_CNT_W'(gcbu_pkg::PROB_FRAC_BITS - 1))
                begin
                    state_next = ST_WRITE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_WRITE:
            begin
                // Hold until the result register can take the transfer
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

[rtl/gcbu_datapath.sv]
// Cell stores, shared multiplier, restoring divider, clamp and result register.
module gcbu_datapath (
    input  logic                    clk,
    input  logic                    rst_n,
    input  gcbu_pkg::ctrl_cmd_t     cmd,
    output gcbu_pkg::dp_status_t    status,
    input  gcbu_pkg::in_item_t      item,
    input  gcbu_pkg::cfg_t          cfg,
    output logic                    result_valid,
    input  logic                    result_ready,
    output gcbu_pkg::out_item_t     result
);

    localparam int PW = gcbu_pkg::PROB_W;
    localparam int DW = gcbu_pkg::DEN_W;

    // Cell stores
    logic [PW-1:0] prob_mem  [gcbu_pkg::NUM_CELLS];
    logic          known_mem [gcbu_pkg::NUM_CELLS];

    logic [gcbu_pkg::IDX_W-1:0]   idx_reg;
    logic [PW-1:0]                lik_reg;
    logic                         lvalid_reg;
    logic [PW-1:0]                prob_rd_reg;
    logic                         known_rd_reg;
    logic [gcbu_pkg::CELL_AW-1:0] clear_addr_reg;
    logic [DW-1:0]                num_reg;
    logic [DW-1:0]                odd_reg;
    logic [DW-1:0]                den_reg;
    logic [DW-1:0]                rem_reg;
    logic [DW-1:0]                rem_next;
    logic [PW-1:0]                q_reg;
    logic [PW-1:0]                q_next;
    logic                         out_valid_reg;
    gcbu_pkg::out_item_t          out_reg;

    logic [gcbu_pkg::CELL_AW-1:0] addr;
    logic                         in_range;
    logic                         lik_zero;
    logic                         lik_one;
    logic [PW-1:0]                p_sat;
    logic [PW-1:0]                mul_a;
    logic [PW-1:0]                mul_b;
    logic [gcbu_pkg::PROD_W-1:0]  prod;
    logic [DW:0]                  rem_sh;
    logic                         rem_ge;
    logic [PW-1:0]                hi_bound;
    logic [PW-1:0]                lo_bound;
    logic [PW-1:0]                fused;
    logic [PW-1:0]                res_prob;
    logic [gcbu_pkg::ACT_W-1:0]   res_act;
    logic                         prob_we;
    logic                         known_we;
    logic [gcbu_pkg::CELL_AW-1:0] known_waddr;

    assign addr     = gcbu_pkg::CELL_AW'(idx_reg);
    assign in_range = 32'(idx_reg) < 32'(gcbu_pkg::NUM_CELLS);
    assign lik_zero = (lik_reg == '0);
    assign lik_one  = (lik_reg == PW'(gcbu_pkg::ONE_Q));
    assign p_sat    = gcbu_pkg::sat_one(32'(prob_rd_reg));

    // Capture the item, likelihood limited to one
    always_ff @(posedge clk)
    begin
        if (cmd.in_load)
        begin
            idx_reg    <= item.cell_index;
            lik_reg    <= gcbu_pkg::sat_one(32'(item.likelihood));
            lvalid_reg <= item.likelihood_valid;
        end
    end

    // Clearing sweep address for the known bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_addr_reg <= '0;
        end
        else if (cmd.clear_step)
        begin
            clear_addr_reg <= clear_addr_reg + 1'b1;
        end
    end

    assign status.clear_last =
        (clear_addr_reg == gcbu_pkg::CELL_AW'(gcbu_pkg::NUM_CELLS - 1));

    // Store writes
    assign prob_we     = cmd.commit && in_range && lvalid_reg;
    assign known_we    = cmd.clear_step || (prob_we && !known_rd_reg);
    assign known_waddr = cmd.clear_step ? clear_addr_reg : addr;

    always_ff @(posedge clk)
    begin
        if (prob_we)
        begin
            prob_mem[addr] <= res_prob;
        end
        if (cmd.mem_rd)
        begin
            prob_rd_reg <= prob_mem[addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (known_we)
        begin
            known_mem[known_waddr] <= !cmd.clear_step;
        end
        if (cmd.mem_rd)
        begin
            known_rd_reg <= known_mem[addr];
        end
    end

    assign status.fuse_path = in_range && lvalid_reg && known_rd_reg && !lik_zero && !lik_one;

    // Shared multiplier: p*l, then (1-p)*(1-l)
    assign mul_a = cmd.mul_odd ? PW'(gcbu_pkg::ONE_Q) - p_sat : p_sat;
    assign mul_b = cmd.mul_odd ? PW'(gcbu_pkg::ONE_Q) - lik_reg : lik_reg;
    assign prod  = gcbu_pkg::PROD_W'(mul_a) * gcbu_pkg::PROD_W'(mul_b);

    always_ff @(posedge clk)
    begin
        if (cmd.mul_num)
        begin
            num_reg <= DW'(prod);
        end
        if (cmd.mul_odd)
        begin
            odd_reg <= DW'(prod);
        end
        if (cmd.den_load)
        begin
            den_reg <= num_reg + odd_reg;
        end
    end

    // Restoring divider, one quotient bit per step
    assign rem_sh = {rem_reg, 1'b0};
    assign rem_ge = (rem_sh >= {1'b0, den_reg});

    always_comb
    begin
        rem_next = rem_reg;
        q_next   = q_reg;
        if (cmd.div_init)
        begin
            if (num_reg >= den_reg)
            begin
                q_next   = PW'(1);
                rem_next = num_reg - den_reg;
            end
            else
            begin
                q_next   = '0;
                rem_next = num_reg;
            end
        end
        else if (cmd.div_step)
        begin
            q_next   = {q_reg[PW-2:0], rem_ge};
            rem_next = rem_ge ? DW'(rem_sh - {1'b0, den_reg}) : DW'(rem_sh);
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    // Fused value, limited to the bounds (lower wins when they cross)
    assign hi_bound = gcbu_pkg::sat_one(32'(cfg.upper_prob));
    assign lo_bound = gcbu_pkg::sat_one(32'(cfg.lower_prob));

    always_comb
    begin
        if (lik_zero || den_reg == '0)
        begin
            fused = '0;
        end
        else
        begin
            fused = q_reg;
        end
        if (lik_one)
        begin
            fused = PW'(gcbu_pkg::ONE_Q);
        end
        if (fused > hi_bound)
        begin
            fused = hi_bound;
        end
        if (fused < lo_bound)
        begin
            fused = lo_bound;
        end
    end

    // Select the result of this step
    always_comb
    begin
        res_prob = '0;
        res_act  = gcbu_pkg::ACT_SKIP;
        if (in_range)
        begin
            if (!lvalid_reg)
            begin
                res_prob = known_rd_reg ? prob_rd_reg : '0;
            end
            else if (!known_rd_reg)
            begin
                res_prob = gcbu_pkg::sat_one(32'(cfg.prior_prob));
                res_act  = gcbu_pkg::ACT_PRIOR;
            end
            else
            begin
                res_prob = fused;
                res_act  = gcbu_pkg::ACT_FUSE;
            end
        end
    end

    // Result register; a new transfer loads only when it is free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_reg.cell_index_out <= idx_reg;
            out_reg.probability    <= gcbu_pkg::OUT_PROB_W'(res_prob);
            out_reg.action         <= res_act;
        end
    end

    assign status.out_free = !out_valid_reg || result_ready;
    assign result_valid    = out_valid_reg;
    assign result          = out_reg;

endmodule

[rtl/grid_cell_bayes_update.sv]
// Top level of the grid cell Bayesian probability update block.
// A fused update goes through the cell read, two passes through the shared multiplier,
// the denominator sum and the 16-step restoring divider to reach the result register.
// First visits, skipped items and saturated likelihoods skip the multiplier and divider.
// One item at a time, taken in the cycle after the previous result loads.
// After reset a clearing sweep of the 65536 cells zeroes the known bits; items wait for it.
`include "grid_cell_bayes_update_defines.svh"

module grid_cell_bayes_update (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [gcbu_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [gcbu_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [gcbu_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    input  logic                              item_valid,
    output logic                              item_ready,
    input  gcbu_pkg::in_item_t                item,
    output logic                              result_valid,
    input  logic                              result_ready,
    output gcbu_pkg::out_item_t               result
);

    gcbu_pkg::cfg_t       cfg;
    gcbu_pkg::ctrl_cmd_t  cmd;
    gcbu_pkg::dp_status_t status;
    logic [5:0]           dp_ops;

    gcbu_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    gcbu_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .status     (status),
        .cmd        (cmd)
    );

    gcbu_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .item         (item),
        .cfg          (cfg),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // Datapath steps never overlap
    assign dp_ops = {cmd.mul_num, cmd.mul_odd, cmd.den_load,
                     cmd.div_init, cmd.div_step, cmd.commit};

    `GCBU_ASSERT_NEXT(a_ready_drops, clk, rst_n, item_valid && item_ready, !item_ready)
    `GCBU_ASSERT_IMPLIES(a_no_item_in_clear, clk, rst_n, cmd.clear_step, !item_ready)
    `GCBU_ASSERT_IMPLIES(a_ops_onehot, clk, rst_n, 1'b1, $onehot0(dp_ops))
    `GCBU_ASSERT_IMPLIES(a_result_from_commit, clk, rst_n, $rose(result_valid), $past(cmd.commit))

endmodule
